[design/min_point_segment_distance_top_assert.svh]
// Assertion macros for the segment distance block.
`ifndef MIN_POINT_SEGMENT_DISTANCE_TOP_ASSERT_SVH
`define MIN_POINT_SEGMENT_DISTANCE_TOP_ASSERT_SVH

// same-cycle implication
`define MPSD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mpsd assertion failed");

// next-cycle implication
`define MPSD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mpsd assertion failed");

`endif

[design/mpsd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package mpsd_pkg;
	localparam int CW   = 32;     // coordinate width
	localparam int DW   = 33;     // coordinate difference width
	localparam int PW   = 66;     // product width
	localparam int SW   = 68;     // sum of products width
	localparam int LW   = 67;     // magnitude of a sum of products
	localparam int NW   = 136;    // root datapath width
	localparam int RB   = 33;     // root result bits
	localparam int NPROD = 10;

	typedef logic signed [DW-1:0] diff_t;

	typedef struct packed {
		logic signed [CW-1:0] sx;
		logic signed [CW-1:0] sy;
		logic signed [CW-1:0] ex;
		logic signed [CW-1:0] ey;
	} seg_t;

	typedef struct packed {
		diff_t ax;
		diff_t ay;
		diff_t bx;
		diff_t by;
		logic  last;
	} item_t;

	typedef struct packed {
		logic          start;
		logic [NW-1:0] num;
		logic [LW-1:0] den;
	} root_req_t;

	typedef struct packed {
		logic          done;
		logic [CW-1:0] root;
	} root_rsp_t;

	typedef enum logic [2:0] {
		B_IDLE, B_MUL, B_PICK, B_SQR, B_RISSUE, B_ROOT, B_UPD, B_OUT
	} bstate_t;

	typedef enum logic [1:0] {
		REG_SX = 2'd0,
		REG_SY = 2'd1,
		REG_EX = 2'd2,
		REG_EY = 2'd3
	} reg_idx_t;
endpackage
`default_nettype wire

[design/mpsd_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module mpsd_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire mpsd_pkg::seg_t  seg,
	input  wire logic            s_tvalid,
	output logic                 s_tready,
	input  wire logic [63:0]     s_tdata,
	input  wire logic            s_tlast,
	output mpsd_pkg::item_t      item,
	output logic                 item_valid,
	input  wire logic            item_pop
);
	import mpsd_pkg::*;

	item_t      mem_q [2];
	item_t      new_item;
	logic       wptr_q, rptr_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	always_comb begin
		new_item.ax   = {s_tdata[31], s_tdata[31:0]} - {seg.sx[CW-1], seg.sx};
		new_item.ay   = {s_tdata[63], s_tdata[63:32]} - {seg.sy[CW-1], seg.sy};
		new_item.bx   = {s_tdata[31], s_tdata[31:0]} - {seg.ex[CW-1], seg.ex};
		new_item.by   = {s_tdata[63], s_tdata[63:32]} - {seg.ey[CW-1], seg.ey};
		new_item.last = s_tlast;
	end

	assign s_tready   = (cnt_q != 2'd2);
	assign item_valid = (cnt_q != 2'd0);
	assign item       = mem_q[rptr_q];
	assign push       = s_tvalid && s_tready;
	assign pop        = item_pop && item_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (pop)  rptr_q <= ~rptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule
`default_nettype wire

[design/mpsd_root.sv]
`timescale 1ns / 1ps
`default_nettype none
// floor(sqrt(num / den)) by restoring digit recurrence
module mpsd_root (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire mpsd_pkg::root_req_t req,
	output mpsd_pkg::root_rsp_t      rsp
);
	import mpsd_pkg::*;

	localparam int BITW = $clog2(RB);

	logic            busy_q, phase_q, done_q;
	logic [BITW-1:0] bit_q;
	logic [RB-1:0]   r_q;
	logic [NW-1:0]   rem_q, ps_q, d2_q, term_q;
	logic            take;
	logic [NW-1:0]   ps_upd;

	assign take   = (rem_q >= term_q);
	assign ps_upd = take ? (ps_q + (d2_q << 1)) : ps_q;

	assign rsp.done = done_q;
	assign rsp.root = r_q[RB-1] ? {CW{1'b1}} : r_q[CW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= 1'b0;
			done_q  <= 1'b0;
			bit_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q  <= 1'b1;
				phase_q <= 1'b0;
				bit_q   <= BITW'(RB - 1);
			end else if (busy_q) begin
				phase_q <= ~phase_q;
				if (phase_q) begin
					if (bit_q == '0) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end else begin
						bit_q <= bit_q - 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num;
			ps_q  <= '0;
			d2_q  <= NW'(req.den) << (2 * (RB - 1));
			r_q   <= '0;
		end else if (busy_q) begin
			if (!phase_q) begin
				term_q <= ps_q + d2_q;
			end else begin
				if (take) begin
					rem_q     <= rem_q - term_q;
					r_q[bit_q] <= 1'b1;
				end
				ps_q <= ps_upd >> 1;
				d2_q <= d2_q >> 2;
			end
		end
	end
endmodule
`default_nettype wire

[design/mpsd_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module mpsd_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire mpsd_pkg::seg_t      seg,
	input  wire mpsd_pkg::item_t     item,
	input  wire logic                item_valid,
	output logic                     item_pop,
	output mpsd_pkg::root_req_t      root_req,
	input  wire mpsd_pkg::root_rsp_t root_rsp,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [31:0]              m_tdata,
	output logic                     m_tuser
);
	import mpsd_pkg::*;

	localparam int STW = $clog2(NPROD + 1);
	localparam int SQC = $clog2(LW);

	bstate_t state_q, state_d;

	item_t                 item_q;
	logic [STW-1:0]        step_q;
	logic signed [PW-1:0]  prod_s1;
	logic signed [SW-1:0]  len2_q, dot_q, cr_q, eb2_q, ea2_q;
	logic [NW-1:0]         num_q, mcand_q;
	logic [LW-1:0]         mplier_q, den_q;
	logic [SQC-1:0]        sq_cnt_q;
	logic                  counted_q;
	logic [CW-1:0]         dist_q, min_q;
	logic                  seen_q;
	logic                  m_tvalid_q, m_tuser_q;
	logic [CW-1:0]         m_tdata_q;

	diff_t                 dx, dy, opa, opb;
	logic signed [SW-1:0]  prod_ext, cr_abs;
	logic                  zero_len, dot_pos, dot_ge, out_free;

	assign dx = {seg.ex[CW-1], seg.ex} - {seg.sx[CW-1], seg.sx};
	assign dy = {seg.ey[CW-1], seg.ey} - {seg.sy[CW-1], seg.sy};

	always_comb begin
		unique case (step_q)
			4'd0:    begin opa = dx;        opb = dx;        end
			4'd1:    begin opa = dy;        opb = dy;        end
			4'd2:    begin opa = item_q.ax; opb = dx;        end
			4'd3:    begin opa = item_q.ay; opb = dy;        end
			4'd4:    begin opa = item_q.ax; opb = dy;        end
			4'd5:    begin opa = item_q.ay; opb = dx;        end
			4'd6:    begin opa = item_q.bx; opb = item_q.bx; end
			4'd7:    begin opa = item_q.by; opb = item_q.by; end
			4'd8:    begin opa = item_q.ax; opb = item_q.ax; end
			4'd9:    begin opa = item_q.ay; opb = item_q.ay; end
			default: begin opa = '0;        opb = '0;        end
		endcase
	end

	assign prod_ext = SW'(prod_s1);
	assign cr_abs   = cr_q[SW-1] ? -cr_q : cr_q;
	assign zero_len = (len2_q == '0);
	assign dot_pos  = !dot_q[SW-1] && (dot_q != '0);
	assign dot_ge   = (dot_q >= len2_q);
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		state_d  = state_q;
		item_pop = 1'b0;
		root_req.start = 1'b0;
		root_req.num   = num_q;
		root_req.den   = den_q;
		unique case (state_q)
			B_IDLE: begin
				if (item_valid) begin
					item_pop = 1'b1;
					state_d  = B_MUL;
				end
			end
			B_MUL: begin
				if (step_q == STW'(NPROD)) state_d = B_PICK;
			end
			B_PICK: begin
				priority if (zero_len)             state_d = B_RISSUE;
				else if (!dot_pos)                 state_d = B_UPD;
				else if (dot_ge)                   state_d = B_RISSUE;
				else                               state_d = B_SQR;
			end
			B_SQR: begin
				if (sq_cnt_q == SQC'(LW - 1)) state_d = B_RISSUE;
			end
			B_RISSUE: begin
				root_req.start = 1'b1;
				state_d = B_ROOT;
			end
			B_ROOT: begin
				if (root_rsp.done) state_d = B_UPD;
			end
			B_UPD: begin
				state_d = item_q.last ? B_OUT : B_IDLE;
			end
			B_OUT: begin
				if (out_free) state_d = B_IDLE;
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// product sequencer, square and root operand setup
	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				item_q <= item;
				step_q <= '0;
				len2_q <= '0;
				dot_q  <= '0;
				cr_q   <= '0;
				eb2_q  <= '0;
				ea2_q  <= '0;
			end
			B_MUL: begin
				prod_s1 <= opa * opb;
				step_q  <= step_q + 1'b1;
				unique case (step_q)
					4'd1, 4'd2:  len2_q <= len2_q + prod_ext;
					4'd3, 4'd4:  dot_q  <= dot_q + prod_ext;
					4'd5:        cr_q   <= cr_q + prod_ext;
					4'd6:        cr_q   <= cr_q - prod_ext;
					4'd7, 4'd8:  eb2_q  <= eb2_q + prod_ext;
					4'd9, 4'd10: ea2_q  <= ea2_q + prod_ext;
					default: ;
				endcase
			end
			B_PICK: begin
				sq_cnt_q <= '0;
				priority if (zero_len) begin
					num_q <= NW'(ea2_q[LW-1:0]);
					den_q <= LW'(1);
				end else if (dot_ge) begin
					num_q <= NW'(eb2_q[LW-1:0]);
					den_q <= LW'(1);
				end else begin
					num_q    <= '0;
					den_q    <= len2_q[LW-1:0];
					mcand_q  <= NW'(cr_abs[LW-1:0]);
					mplier_q <= cr_abs[LW-1:0];
				end
			end
			B_SQR: begin
				if (mplier_q[0]) num_q <= num_q + mcand_q;
				mcand_q  <= mcand_q << 1;
				mplier_q <= mplier_q >> 1;
				sq_cnt_q <= sq_cnt_q + 1'b1;
			end
			B_ROOT: begin
				if (root_rsp.done) dist_q <= root_rsp.root;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counted_q <= 1'b0;
		end else if (state_q == B_PICK) begin
			counted_q <= zero_len || dot_pos;
		end
	end

	// running minimum and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q      <= '1;
			seen_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tuser_q  <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			if (state_q == B_UPD && counted_q) begin
				seen_q <= 1'b1;
				if (dist_q < min_q) min_q <= dist_q;
			end
			if (state_q == B_OUT && out_free) begin
				m_tvalid_q <= 1'b1;
				m_tdata_q  <= seen_q ? min_q : '0;
				m_tuser_q  <= seen_q;
				min_q      <= '1;
				seen_q     <= 1'b0;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
endmodule
`default_nettype wire

[design/min_point_segment_distance_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// channel   | signals                         | payload
// s_axis    | tvalid tready tdata[63:0] tlast | point_x, point_y; tlast = last_point
// m_axis    | tvalid tready tdata[31:0] tuser | min_distance; tuser = any_counted
// apb       | psel penable pwrite paddr pwdata| seg_start_x/y, seg_end_x/y at 0,4,8,12
//
// One point at a time in the back end: every point takes 10 products through one
// multiplier; an end-point or zero-length case then takes the root, an interior
// projection a shift-add squaring and then the root, and a point behind the start
// takes neither. A last point also loads the output register.
// A two-entry queue takes points while the back end works.
// Reset clears registers, queue and running minimum; output stalls hold the back end.
module min_point_segment_distance_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [63:0] s_axis_tdata,   // [31:0] point_x, [63:32] point_y
	input  wire logic        s_axis_tlast,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,   // [31:0] min_distance
	output logic             m_axis_tuser,   // [0] any_counted
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import mpsd_pkg::*;

	seg_t      seg_q;
	item_t     item;
	logic      item_valid, item_pop;
	root_req_t root_req;
	root_rsp_t root_rsp;
	reg_idx_t  idx;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			unique case (idx)
				REG_SX: seg_q.sx <= pwdata;
				REG_SY: seg_q.sy <= pwdata;
				REG_EX: seg_q.ex <= pwdata;
				REG_EY: seg_q.ey <= pwdata;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_SX: prdata = seg_q.sx;
			REG_SY: prdata = seg_q.sy;
			REG_EX: prdata = seg_q.ex;
			REG_EY: prdata = seg_q.ey;
		endcase
	end

	mpsd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.seg        (seg_q),
		.s_tvalid   (s_axis_tvalid),
		.s_tready   (s_axis_tready),
		.s_tdata    (s_axis_tdata),
		.s_tlast    (s_axis_tlast),
		.item       (item),
		.item_valid (item_valid),
		.item_pop   (item_pop)
	);

	mpsd_root u_root (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (root_req),
		.rsp    (root_rsp)
	);

	mpsd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.seg        (seg_q),
		.item       (item),
		.item_valid (item_valid),
		.item_pop   (item_pop),
		.root_req   (root_req),
		.root_rsp   (root_rsp),
		.m_tvalid   (m_axis_tvalid),
		.m_tready   (m_axis_tready),
		.m_tdata    (m_axis_tdata),
		.m_tuser    (m_axis_tuser)
	);
endmodule
`default_nettype wire

[design/mpsd_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "min_point_segment_distance_top_assert.svh"
module mpsd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [31:0] m_axis_tdata,
	input wire logic        m_axis_tuser,
	input wire logic        pready
);
	`MPSD_ASSERT_IMP(a_pready_high, 1'b1, pready)
	`MPSD_ASSERT_IMP(a_empty_set_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == 32'd0)
	`MPSD_ASSERT_NXT(a_valid_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
	`MPSD_ASSERT_NXT(a_data_hold, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser))
endmodule

bind min_point_segment_distance_top mpsd_checker u_chk (.*);
`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
	import mpsd_pkg::*;

	typedef struct {
		logic [31:0] px;
		logic [31:0] py;
		logic        last;
	} point_t;

	typedef struct {
		logic [31:0] min_dist;
		logic        any;
	} min_res_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata = '0;
	logic        s_axis_tlast = 0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [31:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        psel = 0;
	logic        penable = 0;
	logic        pwrite = 0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	point_t   pend_pts[$];
	min_res_t exp_mins[$];
	logic signed [31:0] seg_sx, seg_sy, seg_ex, seg_ey;
	logic [31:0] run_min;
	logic        seen;
	int errors = 0, n_sets = 0, n_counted = 0, n_sat = 0, n_pts = 0;
	int cyc = 0, hold_cnt = 0;
	bit held = 0, s_acc = 0;

	min_point_segment_distance_top dut (.*);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	function automatic logic [31:0] floor_root(logic [199:0] num, logic [199:0] den);
		logic [33:0] r;
		logic [33:0] c;
		logic [199:0] p;
		r = '0;
		for (int b = 32; b >= 0; b--) begin
			c = r | (34'd1 << b);
			p = c;
			p = p * p * den;
			if (p <= num) r = c;
		end
		return (r > 34'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
	endfunction

	function automatic void track_point(point_t pt);
		logic signed [199:0] dx, dy, ax, ay, bx, by, len2, dot, cr;
		logic [31:0] d;
		logic cnt;
		dx = seg_ex - seg_sx; dy = seg_ey - seg_sy;
		dx = $signed(seg_ex) - $signed(seg_sx);
		dy = $signed(seg_ey) - $signed(seg_sy);
		ax = $signed(pt.px) - $signed(seg_sx);
		ay = $signed(pt.py) - $signed(seg_sy);
		bx = $signed(pt.px) - $signed(seg_ex);
		by = $signed(pt.py) - $signed(seg_ey);
		cnt = 0;
		d = 0;
		if (dx == 0 && dy == 0) begin
			d = floor_root(ax * ax + ay * ay, 200'd1);
			cnt = 1;
		end else begin
			len2 = dx * dx + dy * dy;
			dot = ax * dx + ay * dy;
			if (dot > 0) begin
				cnt = 1;
				if (dot >= len2) d = floor_root(bx * bx + by * by, 200'd1);
				else begin
					cr = ax * dy - ay * dx;
					d = floor_root(cr * cr, len2);
				end
			end
		end
		if (cnt) begin
			seen = 1;
			if (d == 32'hFFFF_FFFF) n_sat++;
			if (d < run_min) run_min = d;
		end
		if (pt.last) begin
			exp_mins.insert(exp_mins.size(), '{seen ? run_min : 32'd0, seen});
			n_sets++;
			if (seen) n_counted++;
			run_min = '1;
			seen = 0;
		end
	endfunction

	// request source
	always @(negedge clk) begin
		point_t pt;
		logic nv;
		logic [63:0] nd;
		logic nl;
		cyc++;
		nv = s_axis_tvalid; nd = s_axis_tdata; nl = s_axis_tlast;
		if (!s_axis_tvalid || s_acc) begin
			nv = 0;
			if (pend_pts.size() > 0 && (cyc % 20000 < 3000 || $urandom_range(99) >= 32)) begin
				pt = pend_pts.pop_front();
				nv = 1; nd = {pt.py, pt.px}; nl = pt.last;
			end
		end
		s_axis_tvalid <= nv; s_axis_tdata <= nd; s_axis_tlast <= nl;
	end

	// result sink, with one long hold-off
	always @(negedge clk) begin
		if (!held && n_pts >= 300) begin
			held = 1;
			hold_cnt = 1500;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			m_axis_tready <= 0;
		end else
			m_axis_tready <= (cyc % 20000 < 3000) || ($urandom_range(99) >= 32);
	end

	always @(posedge clk) begin
		min_res_t e;
		point_t pt;
		s_acc = s_axis_tvalid && s_axis_tready;
		if (s_acc) begin
			pt.px = s_axis_tdata[31:0];
			pt.py = s_axis_tdata[63:32];
			pt.last = s_axis_tlast;
			n_pts++;
			track_point(pt);
		end
		if (m_axis_tvalid && m_axis_tready) begin
			if (exp_mins.size() == 0) begin
				$error("unexpected result: min_distance %h any_counted %b",
					m_axis_tdata, m_axis_tuser);
				errors++;
			end else begin
				e = exp_mins.pop_front();
				if (m_axis_tdata !== e.min_dist) begin
					$error("min_distance expected %h actual %h", e.min_dist, m_axis_tdata);
					errors++;
				end
				if (m_axis_tuser !== e.any) begin
					$error("any_counted expected %b actual %b", e.any, m_axis_tuser);
					errors++;
				end
			end
		end
	end

	task automatic write_reg(reg_idx_t idx, logic [31:0] val);
		@(negedge clk);
		psel <= 1; pwrite <= 1; penable <= 0; paddr <= {idx, 2'b00}; pwdata <= val;
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		case (idx)
			REG_SX: seg_sx = val;
			REG_SY: seg_sy = val;
			REG_EX: seg_ex = val;
			REG_EY: seg_ey = val;
		endcase
	endtask

	task automatic set_segment(logic [31:0] sx, logic [31:0] sy, logic [31:0] ex,
			logic [31:0] ey);
		write_reg(REG_SX, sx);
		write_reg(REG_SY, sy);
		write_reg(REG_EX, ex);
		write_reg(REG_EY, ey);
	endtask

	task automatic drain();
		wait (pend_pts.size() == 0 && exp_mins.size() == 0 && !s_axis_tvalid);
		@(negedge clk);
		wait (pend_pts.size() == 0 && exp_mins.size() == 0 && !s_axis_tvalid);
		repeat (200) @(posedge clk);
	endtask

	function automatic void add_pt(logic [31:0] x, logic [31:0] y, logic l);
		pend_pts.insert(pend_pts.size(), '{x, y, l});
	endfunction

	function automatic void add_rand_set(bit wide);
		int n;
		longint k;
		logic [31:0] x, y;
		n = $urandom_range(1, 6);
		for (int i = 0; i < n; i++) begin
			if (wide || $urandom_range(9) == 0) begin
				x = $urandom; y = $urandom;
			end else begin
				k = longint'($urandom_range(0, 12)) - 4;
				x = 32'(longint'(seg_sx) + ((longint'(seg_ex) - longint'(seg_sx)) * k) / 4
					+ longint'($urandom_range(0, 1 << 20)) - (1 << 19));
				y = 32'(longint'(seg_sy) + ((longint'(seg_ey) - longint'(seg_sy)) * k) / 4
					+ longint'($urandom_range(0, 1 << 20)) - (1 << 19));
			end
			add_pt(x, y, i == n - 1);
		end
	endfunction

	initial begin
		logic [31:0] c[4];
		seg_sx = 0; seg_sy = 0; seg_ex = 0; seg_ey = 0;
		run_min = '1; seen = 0;
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n <= 1;

		// zero-length segment at the origin straight out of reset
		add_pt(32'h0001_0000, 32'h0, 0);
		add_pt(32'h0, 32'h0, 1);
		add_pt(32'h7FFF_FFFF, 32'h8000_0000, 1);
		drain();

		// along the x axis, ten units long
		set_segment(32'h0, 32'h0, 32'h000A_0000, 32'h0);
		add_pt(32'hFFFF_0000, 32'h0003_0000, 1);   // behind start only
		add_pt(32'h0, 32'h0005_0000, 1);           // exactly at t = 0
		add_pt(32'h0004_0000, 32'h0002_8000, 0);   // interior
		add_pt(32'h0014_0000, 32'h0, 0);           // past the end
		add_pt(32'h0005_0000, 32'hFFFF_0000, 0);   // no last flag yet
		add_pt(32'hFFF0_0000, 32'h0, 1);
		drain();

		// extreme segment corners
		set_segment(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		add_pt(32'h7FFF_FFFF, 32'h8000_0000, 1);
		add_pt(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1);
		add_pt(32'h8000_0001, 32'h8000_0000, 1);
		add_pt(32'h0, 32'hFFFF_FFFF, 1);
		drain();

		// zero-length at a corner: saturating distance
		set_segment(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		add_pt(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
		add_pt(32'h7FFF_FFFF, 32'h8000_0000, 1);
		add_pt(32'h8000_0000, 32'h8000_0000, 1);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			for (int i = 0; i < 4; i++)
				c[i] = (ph % 3 == 0) ? $urandom : $urandom_range(0, 1 << 24) - (1 << 23);
			if (ph == 5) begin
				c[2] = c[0]; c[3] = c[1];
			end
			set_segment(c[0], c[1], c[2], c[3]);
			while (pend_pts.size() < 110) add_rand_set(ph % 4 == 1);
			drain();
		end

		$display("%0d points in %0d sets, %0d sets with a counted point, %0d saturated",
			n_pts, n_sets, n_counted, n_sat);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#8ms;
		$display("simulation failed");
		$finish;
	end
endmodule
